FILE: hdl/tpq_pkg.sv
// Shared constants for the tree path min/max query block.
package tpq_pkg;

  localparam int NODES_DEF       = 131072;
  localparam int TOP_LEVEL_DEF   = 17;
  localparam int WEIGHT_BITS_DEF = 20;

  // Fixed field widths on the request and response channels
  localparam int NODE_FW   = 17;
  localparam int WEIGHT_FW = 20;

  // Request opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

endpackage

FILE: hdl/tpq_req_if.sv
// Request and response channel interfaces.
interface tpq_req_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [tpq_pkg::NODE_FW-1:0]   node_a;
  logic [tpq_pkg::NODE_FW-1:0]   node_b;
  logic [tpq_pkg::WEIGHT_FW-1:0] edge_weight;

  modport source (output valid, opcode, node_a, node_b, edge_weight, input ready);
  modport sink (input valid, opcode, node_a, node_b, edge_weight, output ready);
endinterface

interface tpq_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [tpq_pkg::WEIGHT_FW-1:0] path_min;
  logic [tpq_pkg::WEIGHT_FW-1:0] path_max;
  logic                         empty_path;

  modport source (output valid, path_min, path_max, empty_path, input ready);
  modport sink (input valid, path_min, path_max, empty_path, output ready);
endinterface

FILE: hdl/tpq_ram.sv
// Single-port-write, single-port-read synchronous RAM with a registered read port.
module tpq_ram #(
  parameter int DW = 8,
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [0:(1<<AW)-1];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/tree_path_min_max_query.sv
// Insert: one row read per level.
// Query: time set by the dependent row-then-depth reads of the lift and
//   the two row reads per level of the common-ancestor climb; one request
//   at a time.
// A response sits in an output register; the next request is taken meanwhile.
// Synchronous reset clears control only; node 0 is hardwired as the root row.
module tree_path_min_max_query #(
  parameter int NODES       = tpq_pkg::NODES_DEF,
  parameter int TOP_LEVEL   = tpq_pkg::TOP_LEVEL_DEF,
  parameter int WEIGHT_BITS = tpq_pkg::WEIGHT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  tpq_req_if.sink   req,
  tpq_rsp_if.source rsp
);

  localparam int NB  = $clog2(NODES);
  localparam int LB  = $clog2(TOP_LEVEL + 1);
  localparam int WB  = WEIGHT_BITS;
  localparam int RW  = NB + 2 * WB;
  localparam int RAW = NB + LB;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_IDEP = 4'd1;
  localparam logic [3:0] S_IROW = 4'd2;
  localparam logic [3:0] S_IRD  = 4'd3;
  localparam logic [3:0] S_IWR  = 4'd4;
  localparam logic [3:0] S_QDA  = 4'd5;
  localparam logic [3:0] S_QDB  = 4'd6;
  localparam logic [3:0] S_QSW  = 4'd7;
  localparam logic [3:0] S_LRD  = 4'd8;
  localparam logic [3:0] S_LDEP = 4'd9;
  localparam logic [3:0] S_LCHK = 4'd10;
  localparam logic [3:0] S_BRDA = 4'd11;
  localparam logic [3:0] S_BRDB = 4'd12;
  localparam logic [3:0] S_BCHK = 4'd13;
  localparam logic [3:0] S_FRB  = 4'd14;
  localparam logic [3:0] S_DONE = 4'd15;

  localparam logic [LB-1:0] LVL_TOP = LB'(TOP_LEVEL);
  localparam logic [NB-1:0] DEP_MAX = NB'(NODES - 1);
  localparam logic [WB-1:0] W_ONES  = {WB{1'b1}};

  logic [3:0]    state, state_next;
  logic [NB-1:0] a, b, t_anc;
  logic [WB-1:0] w, mn, mx, t_min, t_max;
  logic [NB-1:0] da, db;
  logic [LB-1:0] lvl;
  logic          final_step;
  logic          q_empty;

  // Final pair of level-0 edges reuses the pairwise compare with a flag
  logic fin;

  logic          out_valid;
  logic [WB-1:0] out_min, out_max;
  logic          out_empty;

  // Memory ports
  logic           dep_we, row_we;
  logic [NB-1:0]  dep_waddr, dep_wdata, dep_raddr, dep_q, dep_val;
  logic [RAW-1:0] row_waddr, row_raddr;
  logic [RW-1:0]  row_wdata, row_q;
  logic           dep_zero, row_zero;
  logic [NB-1:0]  r_anc;
  logic [WB-1:0]  r_min, r_max, n_min, n_max;

  // Request field mapping
  logic [NB-1:0] in_a, in_b;
  logic          in_a_ok, in_b_ok;
  logic          swap;

  assign in_a_ok = 32'(req.node_a) < 32'(NODES);
  assign in_b_ok = 32'(req.node_b) < 32'(NODES);
  assign in_a    = in_a_ok ? NB'(32'(req.node_a)) : '0;
  assign in_b    = in_b_ok ? NB'(32'(req.node_b)) : '0;

  tpq_ram #(.DW(NB), .AW(NB)) u_dep (
    .clk(clk), .we(dep_we), .waddr(dep_waddr), .wdata(dep_wdata),
    .raddr(dep_raddr), .rdata(dep_q)
  );

  tpq_ram #(.DW(RW), .AW(RAW)) u_row (
    .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
    .raddr(row_raddr), .rdata(row_q)
  );

  // Node 0 is the virtual root: depth 0, self ancestor, neutral weights
  always_ff @(posedge clk) begin
    dep_zero <= (dep_raddr == '0);
    row_zero <= (row_raddr[RAW-1:LB] == '0);
  end

  assign dep_val = dep_zero ? '0 : dep_q;
  assign r_anc   = row_zero ? '0 : row_q[RW-1:2*WB];
  assign r_min   = row_zero ? W_ONES : row_q[2*WB-1:WB];
  assign r_max   = row_zero ? '0 : row_q[WB-1:0];
  assign n_min   = (r_min < t_min) ? r_min : t_min;
  assign n_max   = (r_max > t_max) ? r_max : t_max;
  assign swap    = da < dep_val;

  // Read addresses
  always_comb begin
    dep_raddr = a;
    row_raddr = {a, lvl};
    unique case (state)
      S_IDEP:  dep_raddr = b;
      S_QDB:   dep_raddr = b;
      S_LDEP:  dep_raddr = r_anc;
      S_IRD:   row_raddr = {t_anc, lvl - LB'(1)};
      S_BRDB:  row_raddr = {b, lvl};
      // level-0 row of side a as it stands after this compare
      S_BCHK:  row_raddr = {(fin || t_anc != r_anc) ? t_anc : a, {LB{1'b0}}};
      S_FRB:   row_raddr = {b, {LB{1'b0}}};
      default: row_raddr = {a, lvl};
    endcase
  end

  // Table writes during insert
  always_comb begin
    dep_we    = (state == S_IROW);
    dep_waddr = a;
    dep_wdata = (dep_val >= DEP_MAX) ? DEP_MAX : dep_val + NB'(1);
    row_we    = (state == S_IROW) || (state == S_IWR);
    row_waddr = {a, (state == S_IROW) ? {LB{1'b0}} : lvl};
    row_wdata = (state == S_IROW) ? {b, w, w} : {r_anc, n_min, n_max};
  end

  assign final_step = (lvl == '0);

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (req.opcode == tpq_pkg::OP_INSERT) begin
            state_next = (in_a_ok && in_a != '0) ? S_IDEP : S_DONE;
          end else begin
            state_next = (in_a == in_b) ? S_DONE : S_QDA;
          end
        end
      end
      S_IDEP:  state_next = S_IROW;
      S_IROW:  state_next = S_IRD;
      S_IRD:   state_next = S_IWR;
      S_IWR:   state_next = (lvl == LVL_TOP) ? S_DONE : S_IRD;
      S_QDA:   state_next = S_QDB;
      S_QDB:   state_next = S_QSW;
      S_QSW:   state_next = (da != dep_val) ? S_LRD : S_BRDA;
      S_LRD:   state_next = S_LDEP;
      S_LDEP:  state_next = S_LCHK;
      S_LCHK: begin
        if (!final_step) begin
          state_next = S_LRD;
        end else if ((dep_val >= db ? t_anc : a) == b) begin
          state_next = S_DONE;
        end else begin
          state_next = S_BRDA;
        end
      end
      S_BRDA:  state_next = S_BRDB;
      S_BRDB:  state_next = S_BCHK;
      S_BCHK:  state_next = fin ? S_DONE : (final_step ? S_FRB : S_BRDA);
      S_FRB:   state_next = S_BCHK;
      S_DONE:  state_next = (!out_valid || rsp.ready) ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fin   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) begin
        fin <= 1'b0;
      end else if (state == S_FRB) begin
        fin <= 1'b1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        a       <= in_a;
        b       <= in_b;
        w       <= WB'(32'(req.edge_weight));
        mn      <= W_ONES;
        mx      <= '0;
        q_empty <= (req.opcode == tpq_pkg::OP_QUERY) && (in_a == in_b);
      end
      S_IROW: begin
        t_anc <= b;
        t_min <= w;
        t_max <= w;
        lvl   <= LB'(1);
      end
      S_IWR: begin
        t_anc <= r_anc;
        t_min <= n_min;
        t_max <= n_max;
        lvl   <= lvl + LB'(1);
      end
      S_QDB:  da <= dep_val;
      S_QSW: begin
        lvl <= LVL_TOP;
        if (swap) begin
          a  <= b;
          b  <= a;
          da <= dep_val;
          db <= da;
        end else begin
          db <= dep_val;
        end
      end
      S_LDEP: begin
        t_anc <= r_anc;
        t_min <= r_min;
        t_max <= r_max;
      end
      S_LCHK: begin
        if (dep_val >= db) begin
          a  <= t_anc;
          mn <= (t_min < mn) ? t_min : mn;
          mx <= (t_max > mx) ? t_max : mx;
        end
        lvl <= final_step ? LVL_TOP : lvl - LB'(1);
      end
      S_BRDB, S_FRB: begin
        t_anc <= r_anc;
        t_min <= (r_min < mn) ? r_min : mn;
        t_max <= (r_max > mx) ? r_max : mx;
      end
      S_BCHK: begin
        if (fin || t_anc != r_anc) begin
          mn <= n_min;
          mx <= n_max;
          a  <= t_anc;
          b  <= r_anc;
        end
        if (!final_step) begin
          lvl <= lvl - LB'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || rsp.ready)) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || rsp.ready)) begin
      out_min   <= mn;
      out_max   <= mx;
      out_empty <= q_empty;
    end
  end

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.path_min   = tpq_pkg::WEIGHT_FW'(32'(out_min));
  assign rsp.path_max   = tpq_pkg::WEIGHT_FW'(32'(out_max));
  assign rsp.empty_path = out_empty;

  // A taken request always moves the sequencer out of idle
  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state != S_IDLE))
    else $error("sequencer stayed idle after a request");

  // Level counter never runs past the top level while walking levels
  a_lvl_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && state != S_DONE && state != S_QDA && state != S_QDB &&
     state != S_IDEP && state != S_IROW && state != S_QSW)
      |-> (lvl <= LVL_TOP))
    else $error("level counter out of range");

  // Empty path reports the neutral (zero) maximum
  a_empty_neutral: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.empty_path) |-> (rsp.path_max == '0))
    else $error("empty path with nonzero maximum");

  // Lift phase is entered only with unequal endpoint depths
  a_lift_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_QSW) |=> (state != S_LRD || da != db))
    else $error("lift entered with equal depths");

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the tree path min/max query block.
`timescale 1ns / 1ps

module tb_top;

  localparam int NODES  = tpq_pkg::NODES_DEF;
  localparam int LEVELS = tpq_pkg::TOP_LEVEL_DEF + 1;
  localparam logic [tpq_pkg::WEIGHT_FW-1:0] W_ALL = {tpq_pkg::WEIGHT_FW{1'b1}};
  localparam int RANDOM_ITEMS = 450;

  typedef logic [tpq_pkg::NODE_FW-1:0]   node_t;
  typedef logic [tpq_pkg::WEIGHT_FW-1:0] weight_t;

  typedef struct packed {
    logic    op;
    node_t   a;
    node_t   b;
    weight_t w;
  } tree_req_t;

  typedef struct packed {
    weight_t mn;
    weight_t mx;
    logic    empty;
  } path_res_t;

  // Directed row: request plus an optional hand-written answer
  typedef struct packed {
    tree_req_t req;
    logic      fixed;
    path_res_t res;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tpq_req_if req ();
  tpq_rsp_if rsp ();

  tree_path_min_max_query uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the lifting tables
  int unsigned node_depth [int];
  int unsigned node_up    [int];
  weight_t     jump_lo    [int];
  weight_t     jump_hi    [int];

  path_res_t pending_paths [$];
  int        inserted [$];
  bit        is_live  [int];
  int        errors = 0;
  int        n_results = 0;
  int        n_queries = 0;
  int        n_inserts = 0;

  function automatic int key(int n, int l);
    return n * LEVELS + l;
  endfunction

  function automatic weight_t wmin(weight_t x, weight_t y);
    return (x < y) ? x : y;
  endfunction

  function automatic weight_t wmax(weight_t x, weight_t y);
    return (x > y) ? x : y;
  endfunction

  function automatic void clear_tree();
    node_depth.delete();
    node_up.delete();
    jump_lo.delete();
    jump_hi.delete();
    node_depth[0] = 0;
    for (int l = 0; l < LEVELS; l++) begin
      node_up[key(0, l)] = 0;
      jump_lo[key(0, l)] = W_ALL;
      jump_hi[key(0, l)] = '0;
    end
  endfunction

  function automatic void add_node(int n, int p, weight_t w);
    int unsigned d;
    int mid;
    d = node_depth[p];
    node_depth[n] = (d >= NODES - 1) ? NODES - 1 : d + 1;
    node_up[key(n, 0)] = p;
    jump_lo[key(n, 0)] = w;
    jump_hi[key(n, 0)] = w;
    for (int l = 1; l < LEVELS; l++) begin
      mid = node_up[key(n, l - 1)];
      node_up[key(n, l)] = node_up[key(mid, l - 1)];
      jump_lo[key(n, l)] = wmin(jump_lo[key(mid, l - 1)], jump_lo[key(n, l - 1)]);
      jump_hi[key(n, l)] = wmax(jump_hi[key(mid, l - 1)], jump_hi[key(n, l - 1)]);
    end
  endfunction

  function automatic path_res_t path_extremes(int a, int b);
    path_res_t r;
    int t, ua, ub;
    r.mn = W_ALL;
    r.mx = '0;
    r.empty = 1'b0;
    if (node_depth[a] < node_depth[b]) begin
      t = a; a = b; b = t;
    end
    // lift the deeper endpoint to the other's depth
    if (node_depth[a] != node_depth[b]) begin
      for (int l = LEVELS - 1; l >= 0; l--) begin
        ua = node_up[key(a, l)];
        if (node_depth[ua] >= node_depth[b]) begin
          r.mn = wmin(r.mn, jump_lo[key(a, l)]);
          r.mx = wmax(r.mx, jump_hi[key(a, l)]);
          a = ua;
        end
      end
    end
    // climb both to just below the common ancestor
    if (a != b) begin
      for (int l = LEVELS - 1; l >= 0; l--) begin
        ua = node_up[key(a, l)];
        ub = node_up[key(b, l)];
        if (ua != ub) begin
          r.mn = wmin(r.mn, wmin(jump_lo[key(a, l)], jump_lo[key(b, l)]));
          r.mx = wmax(r.mx, wmax(jump_hi[key(a, l)], jump_hi[key(b, l)]));
          a = ua;
          b = ub;
        end
      end
      r.mn = wmin(r.mn, wmin(jump_lo[key(a, 0)], jump_lo[key(b, 0)]));
      r.mx = wmax(r.mx, wmax(jump_hi[key(a, 0)], jump_hi[key(b, 0)]));
    end
    return r;
  endfunction

  // Apply one request to the shadow tables and return its answer
  function automatic path_res_t predict_path(tree_req_t q);
    path_res_t r;
    r.mn = W_ALL;
    r.mx = '0;
    r.empty = 1'b0;
    if (q.op == tpq_pkg::OP_INSERT) begin
      if (q.a != 0) begin
        add_node(int'(q.a), int'(q.b), q.w);
        if (!is_live.exists(int'(q.a))) begin
          is_live[int'(q.a)] = 1'b1;
          inserted = {inserted, int'(q.a)};
        end
      end
    end else if (q.a == q.b) begin
      r.empty = 1'b1;
    end else begin
      r = path_extremes(int'(q.a), int'(q.b));
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
             n_results, field, got, want);
    errors++;
  endtask

  // Send one request after a random gap, or none in burst mode; record what it should return
  task automatic send_request(tree_req_t q, bit fixed, path_res_t fixed_res, bit burst);
    int gap;
    path_res_t r;
    gap = burst ? 0 :
          (($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(5, 40));
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    r = predict_path(q);
    pending_paths = {pending_paths, (fixed ? fixed_res : r)};
    if (q.op == tpq_pkg::OP_QUERY) n_queries++;
    else n_inserts++;
    req.valid       <= 1'b1;
    req.opcode      <= q.op;
    req.node_a      <= q.a;
    req.node_b      <= q.b;
    req.edge_weight <= q.w;
    @(posedge clk);
    while (!(req.valid && req.ready)) @(posedge clk);
  endtask

  // Receiver: random stalls, compare each accepted result
  int stall_left = 0;
  bit no_stall_phase = 1'b0;

  always @(posedge clk) begin
    path_res_t want;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (pending_paths.size() == 0) begin
          $display("unexpected result with nothing outstanding");
          errors++;
        end else begin
          want = pending_paths.pop_front();
          if (rsp.path_min !== want.mn) report_mismatch("path_min", rsp.path_min, want.mn);
          if (rsp.path_max !== want.mx) report_mismatch("path_max", rsp.path_max, want.mx);
          if (rsp.empty_path !== want.empty)
            report_mismatch("empty_path", rsp.empty_path, want.empty);
        end
        n_results++;
      end
      if ($urandom_range(0, 199) == 0) no_stall_phase <= ~no_stall_phase;
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        rsp.ready <= 1'b0;
      end else if (!no_stall_phase && $urandom_range(0, 3) == 0) begin
        stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(10, 40);
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  function automatic tree_req_t mk(logic op, int a, int b, weight_t w);
    tree_req_t q;
    q.op = op;
    q.a = node_t'(a);
    q.b = node_t'(b);
    q.w = w;
    return q;
  endfunction

  function automatic int pick_node();
    if (inserted.size() == 0 || $urandom_range(0, 9) == 0) return 0;
    return inserted[$urandom_range(0, inserted.size() - 1)];
  endfunction

  function automatic weight_t pick_weight();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return W_ALL;
      default: return weight_t'($urandom);
    endcase
  endfunction

  function automatic tree_req_t random_request();
    int n, p, a;
    if (inserted.size() < 4 || $urandom_range(0, 99) < 45) begin
      // insert: mostly fresh nodes, chained under recent ones for depth
      case ($urandom_range(0, 19))
        0:       n = 0;
        1, 2:    n = (inserted.size() > 0) ? inserted[$urandom_range(0, inserted.size() - 1)] : 1;
        3:       n = $urandom_range(0, 1) ? NODES - 1 : 1;
        default: begin
          n = $urandom_range(1, NODES - 1);
          while (is_live.exists(n)) n = $urandom_range(1, NODES - 1);
        end
      endcase
      if (inserted.size() == 0 || $urandom_range(0, 9) == 0) p = 0;
      else if ($urandom_range(0, 1))
        p = inserted[inserted.size() - 1 - $urandom_range(0, (inserted.size() > 3) ? 3 : inserted.size() - 1)];
      else p = pick_node();
      if (p == n) p = 0;
      if (n == 0 && $urandom_range(0, 1)) p = pick_node();
      return mk(tpq_pkg::OP_INSERT, n, p, pick_weight());
    end
    a = pick_node();
    return mk(tpq_pkg::OP_QUERY, a, ($urandom_range(0, 9) == 0) ? a : pick_node(),
              weight_t'($urandom));
  endfunction

  directed_row_t directed [] = '{
    // after reset: root with itself is empty
    '{'{tpq_pkg::OP_QUERY, 17'd0, 17'd0, 20'h12345}, 1'b1, '{W_ALL, 20'h0, 1'b1}},
    '{'{tpq_pkg::OP_INSERT, 17'd1, 17'd0, 20'h00000}, 1'b1, '{W_ALL, 20'h0, 1'b0}},
    '{'{tpq_pkg::OP_INSERT, 17'h1FFFF, 17'd1, 20'hFFFFF}, 1'b1, '{W_ALL, 20'h0, 1'b0}},
    // node 0 insert is dropped
    '{'{tpq_pkg::OP_INSERT, 17'd0, 17'd1, 20'h55555}, 1'b1, '{W_ALL, 20'h0, 1'b0}},
    '{'{tpq_pkg::OP_QUERY, 17'd1, 17'h1FFFF, 20'h0}, 1'b1, '{20'hFFFFF, 20'hFFFFF, 1'b0}},
    '{'{tpq_pkg::OP_QUERY, 17'h1FFFF, 17'd0, 20'hFFFFF}, 1'b1, '{20'h00000, 20'hFFFFF, 1'b0}},
    '{'{tpq_pkg::OP_QUERY, 17'h1FFFF, 17'h1FFFF, 20'h0}, 1'b1, '{W_ALL, 20'h0, 1'b1}},
    '{'{tpq_pkg::OP_INSERT, 17'd2, 17'd1, 20'hAAAAA}, 1'b0, '0},
    '{'{tpq_pkg::OP_INSERT, 17'd3, 17'd2, 20'h55555}, 1'b0, '0},
    '{'{tpq_pkg::OP_INSERT, 17'd4, 17'd3, 20'h00F0F}, 1'b0, '0},
    '{'{tpq_pkg::OP_INSERT, 17'd5, 17'd4, 20'hF0F0F}, 1'b0, '0},
    '{'{tpq_pkg::OP_INSERT, 17'h10000, 17'd0, 20'h7FFFF}, 1'b0, '0},
    // different branches, different root subtrees, node 0 endpoint, ancestor
    '{'{tpq_pkg::OP_QUERY, 17'd5, 17'h1FFFF, 20'h0}, 1'b0, '0},
    '{'{tpq_pkg::OP_QUERY, 17'd3, 17'h10000, 20'h0}, 1'b0, '0},
    '{'{tpq_pkg::OP_QUERY, 17'd0, 17'd5, 20'h0}, 1'b0, '0},
    '{'{tpq_pkg::OP_QUERY, 17'd5, 17'd1, 20'h0}, 1'b0, '0},
    // re-insert: descendants keep old rows
    '{'{tpq_pkg::OP_INSERT, 17'd3, 17'h10000, 20'h00001}, 1'b0, '0},
    '{'{tpq_pkg::OP_QUERY, 17'd5, 17'd3, 20'h0}, 1'b0, '0},
    '{'{tpq_pkg::OP_QUERY, 17'd5, 17'h10000, 20'h0}, 1'b0, '0},
    '{'{tpq_pkg::OP_QUERY, 17'd4, 17'd2, 20'h0}, 1'b0, '0}
  };

  initial begin
    req.valid = 1'b0;
    req.opcode = tpq_pkg::OP_INSERT;
    req.node_a = '0;
    req.node_b = '0;
    req.edge_weight = '0;
    clear_tree();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i])
      send_request(directed[i].req, directed[i].fixed, directed[i].res, 1'b0);

    for (int i = 0; i < RANDOM_ITEMS; i++)
      send_request(random_request(), 1'b0, '0, (i % 100) >= 80);
    req.valid <= 1'b0;

    while (pending_paths.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);

    $display("covered %0d inserts and %0d queries over %0d live nodes, %0d results",
             n_inserts, n_queries, inserted.size(), n_results);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", pending_paths.size());
    $display("FAIL");
    $finish;
  end

endmodule

FILE: sim.f
hdl/tpq_pkg.sv
hdl/tpq_req_if.sv
hdl/tpq_ram.sv
hdl/tree_path_min_max_query.sv
tb/sv/tb_top.sv
